// ----- src/wrbf_pkg.sv -----
`timescale 1ns / 1ps
// wrbf_pkg: types, constants and helpers for the Wendland RBF displacement evaluator.
// No dependencies.
package wrbf_pkg;

    localparam int CNT_W    = 13;
    localparam int SQ_STEPS = 20;

    localparam logic [19:0] KERN_LIM  = 20'd655360;
    localparam logic [41:0] D2_MAX    = 42'd429496729600;
    localparam logic [16:0] ONE_Q16   = 17'd65536;
    localparam logic [20:0] RECIP_10  = 21'd1677722;
    localparam int          RECIP_SH  = 24;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    typedef struct packed {
        logic               valid;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [32:0] dz;
        logic signed [31:0] wx;
        logic signed [31:0] wy;
        logic signed [31:0] wz;
    } kern_in_t;

    typedef struct packed {
        logic               valid;
        logic signed [49:0] tx;
        logic signed [49:0] ty;
        logic signed [49:0] tz;
    } term_t;

    typedef struct packed {
        logic [31:0] value;
        logic        sat;
    } sat_out_t;

    function automatic sat_out_t sat_q16(input logic signed [63:0] acc);
        logic signed [47:0] sh;
        sat_out_t           res;
        sh = 48'(acc >>> 16);
        if (sh > 48'sh0000_7FFF_FFFF) begin
            res.value = 32'h7FFF_FFFF;
            res.sat   = 1'b1;
        end else if (sh < -48'sh0000_8000_0000) begin
            res.value = 32'h8000_0000;
            res.sat   = 1'b1;
        end else begin
            res.value = sh[31:0];
            res.sat   = 1'b0;
        end
        return res;
    endfunction

endpackage

// ----- src/wendland_rbf_displacement_eval.sv -----
`timescale 1ns / 1ps
// wendland_rbf_displacement_eval: top level, control point memory, query sequencer, accumulators.
// Depends on wrbf_pkg, wrbf_ram, wrbf_kernel.
//
//  channel   | handshake      | payload
//  ----------+----------------+--------------------------------------------------
//  request   | start / busy   | req_type, point_index, pos_x/y/z, weight_x/y/z
//  result    | done (strobe)  | disp_x/y/z, saturated
//  config    | cfg_we         | cfg_wdata (num_points)
//
// A load leaves busy low. A query holds busy while it reads min(num_points,
// MAX_POINTS) control points, one per cycle, through the memory read port, ends
// the scan, passes them through the 29 kernel pipeline stages and sees the
// pipeline empty. done pulses for one cycle and busy falls with it. Reset clears
// num_points and control only; the memory is not cleared. The receiver cannot
// stall.
module wendland_rbf_displacement_eval #(
    parameter int MAX_POINTS = 2048
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               req_type,
    input  logic [10:0]        point_index,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] weight_x,
    input  logic signed [31:0] weight_y,
    input  logic signed [31:0] weight_z,
    input  logic               cfg_we,
    input  logic [11:0]        cfg_wdata,
    output logic               done,
    output logic signed [31:0] disp_x,
    output logic signed [31:0] disp_y,
    output logic signed [31:0] disp_z,
    output logic               saturated
);
    import wrbf_pkg::*;

    localparam int AW = MAX_POINTS > 1 ? $clog2(MAX_POINTS) : 1;

    state_t             state_reg, state_next;
    logic [11:0]        num_points_reg;
    logic [CNT_W-1:0]   cnt_reg, n_reg;
    logic               rd_pend_reg, done_reg;
    logic signed [31:0] qx_reg, qy_reg, qz_reg;
    logic signed [63:0] acc_x_reg, acc_y_reg, acc_z_reg;
    logic [31:0]        disp_x_reg, disp_y_reg, disp_z_reg;
    logic               sat_reg;

    logic               accept, ram_we, ram_re, kern_busy;
    logic [CNT_W-1:0]   idx_ext, n_cap;
    logic [191:0]       ram_rdata;
    kern_in_t           kin;
    term_t              kout;
    sat_out_t           fx, fy, fz;

    assign accept  = start && !busy;
    assign idx_ext = CNT_W'(point_index);
    assign ram_we  = accept && !req_type && (idx_ext < CNT_W'(MAX_POINTS));
    assign ram_re  = (state_reg == ST_RUN) && (cnt_reg < n_reg);
    assign n_cap   = (CNT_W'(num_points_reg) > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                                    : CNT_W'(num_points_reg);

    wrbf_ram #(
        .WIDTH (192),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_ext[AW-1:0]),
        .wdata ({pos_x, pos_y, pos_z, weight_x, weight_y, weight_z}),
        .re    (ram_re),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign kin.valid = rd_pend_reg;
    assign kin.dx    = 33'(qx_reg) - 33'($signed(ram_rdata[191:160]));
    assign kin.dy    = 33'(qy_reg) - 33'($signed(ram_rdata[159:128]));
    assign kin.dz    = 33'(qz_reg) - 33'($signed(ram_rdata[127:96]));
    assign kin.wx    = ram_rdata[95:64];
    assign kin.wy    = ram_rdata[63:32];
    assign kin.wz    = ram_rdata[31:0];

    wrbf_kernel u_kernel (
        .clk   (clk),
        .rst_n (rst_n),
        .kin   (kin),
        .kout  (kout),
        .busy  (kern_busy)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && req_type)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (!ram_re)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_pend_reg && !kern_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            num_points_reg <= '0;
            cnt_reg        <= '0;
            rd_pend_reg    <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= ram_re;
            done_reg    <= (state_reg == ST_DRAIN) && (state_next == ST_IDLE);
            if (cfg_we)
            begin
                num_points_reg <= cfg_wdata;
            end
            if (accept)
            begin
                cnt_reg <= '0;
            end
            else if (ram_re)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    assign fx = sat_q16(acc_x_reg);
    assign fy = sat_q16(acc_y_reg);
    assign fz = sat_q16(acc_z_reg);

    always_ff @(posedge clk)
    begin
        if (accept && req_type)
        begin
            qx_reg    <= pos_x;
            qy_reg    <= pos_y;
            qz_reg    <= pos_z;
            n_reg     <= n_cap;
            acc_x_reg <= '0;
            acc_y_reg <= '0;
            acc_z_reg <= '0;
        end
        else if (kout.valid)
        begin
            acc_x_reg <= acc_x_reg + 64'(kout.tx);
            acc_y_reg <= acc_y_reg + 64'(kout.ty);
            acc_z_reg <= acc_z_reg + 64'(kout.tz);
        end
        if ((state_reg == ST_DRAIN) && (state_next == ST_IDLE))
        begin
            disp_x_reg <= fx.value;
            disp_y_reg <= fy.value;
            disp_z_reg <= fz.value;
            sat_reg    <= fx.sat | fy.sat | fz.sat;
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign disp_x    = disp_x_reg;
    assign disp_y    = disp_y_reg;
    assign disp_z    = disp_z_reg;
    assign saturated = sat_reg;

    a_done_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_DRAIN))
        else $error("result strobe without a finished query");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!rd_pend_reg && !kern_busy && !kout.valid))
        else $error("points still in flight while idle");

    a_no_write_in_query: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_IDLE))
        else $error("memory written during a query");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> (cnt_reg < CNT_W'(MAX_POINTS)))
        else $error("read beyond capacity");
endmodule

// ----- src/wrbf_ram.sv -----
`timescale 1ns / 1ps
// wrbf_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module wrbf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ----- src/wrbf_kernel.sv -----
`timescale 1ns / 1ps
// wrbf_kernel: pipelined Wendland C2 kernel and weight product, one point per cycle.
// Depends on wrbf_pkg.
module wrbf_kernel (
    input  logic               clk,
    input  logic               rst_n,
    input  wrbf_pkg::kern_in_t kin,
    output wrbf_pkg::term_t    kout,
    output logic               busy
);
    import wrbf_pkg::*;

    logic [95:0] a_w_reg, b_w_reg, c_w_reg, d_w_reg, e_w_reg, f_w_reg, g_w_reg;
    logic        a_v_reg, b_v_reg, c_v_reg, d_v_reg, e_v_reg, f_v_reg, g_v_reg;
    logic        a_ok_reg, b_ok_reg, c_ok_reg, d_ok_reg, e_ok_reg, f_ok_reg;
    logic [19:0] a_x_reg, a_y_reg, a_z_reg;
    logic [39:0] b_x_reg, b_y_reg, b_z_reg;
    logic [39:0] c_d2_reg;
    logic [40:0] d_prod_reg;
    logic [16:0] e_r_reg, e_u2_reg, f_r_reg, f_u4_reg, g_k_reg;
    logic        h_v_reg;
    logic signed [49:0] h_tx_reg, h_ty_reg, h_tz_reg;

    logic [22:0] sq_rem_reg  [0:SQ_STEPS];
    logic [19:0] sq_root_reg [0:SQ_STEPS];
    logic [39:0] sq_val_reg  [0:SQ_STEPS];
    logic [95:0] sq_w_reg    [0:SQ_STEPS];
    logic        sq_ok_reg   [0:SQ_STEPS];
    logic        sq_v_reg    [0:SQ_STEPS];

    logic [32:0] ax, ay, az;
    logic [41:0] d2_sum;
    logic [16:0] r_next, u_next;
    logic [33:0] uu, u2u2;
    logic [18:0] p_next;
    logic [35:0] kp;
    logic [SQ_STEPS:0] sq_v_vec;

    assign ax = kin.dx[32] ? 33'(-kin.dx) : kin.dx;
    assign ay = kin.dy[32] ? 33'(-kin.dy) : kin.dy;
    assign az = kin.dz[32] ? 33'(-kin.dz) : kin.dz;
    assign d2_sum = 42'(b_x_reg) + 42'(b_y_reg) + 42'(b_z_reg);
    assign r_next = d_prod_reg[RECIP_SH +: 17];
    assign u_next = ONE_Q16 - r_next;
    assign uu     = u_next * u_next;
    assign u2u2   = e_u2_reg * e_u2_reg;
    assign p_next = {f_r_reg, 2'b00} + 19'(ONE_Q16);
    assign kp     = f_u4_reg * p_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
            f_v_reg <= 1'b0;
            g_v_reg <= 1'b0;
            h_v_reg <= 1'b0;
        end
        else
        begin
            a_v_reg <= kin.valid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            d_v_reg <= sq_v_reg[SQ_STEPS];
            e_v_reg <= d_v_reg;
            f_v_reg <= e_v_reg;
            g_v_reg <= f_v_reg;
            h_v_reg <= g_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_w_reg  <= {kin.wx, kin.wy, kin.wz};
        a_ok_reg <= (ax <= 33'(KERN_LIM)) && (ay <= 33'(KERN_LIM)) && (az <= 33'(KERN_LIM));
        a_x_reg  <= ax[19:0];
        a_y_reg  <= ay[19:0];
        a_z_reg  <= az[19:0];

        b_w_reg  <= a_w_reg;
        b_ok_reg <= a_ok_reg;
        b_x_reg  <= a_x_reg * a_x_reg;
        b_y_reg  <= a_y_reg * a_y_reg;
        b_z_reg  <= a_z_reg * a_z_reg;

        c_w_reg  <= b_w_reg;
        c_ok_reg <= b_ok_reg && (d2_sum <= D2_MAX);
        c_d2_reg <= d2_sum[39:0];

        d_w_reg    <= sq_w_reg[SQ_STEPS];
        d_ok_reg   <= sq_ok_reg[SQ_STEPS];
        d_prod_reg <= sq_root_reg[SQ_STEPS] * RECIP_10;

        e_w_reg  <= d_w_reg;
        e_ok_reg <= d_ok_reg;
        e_r_reg  <= r_next;
        e_u2_reg <= uu[32:16];

        f_w_reg  <= e_w_reg;
        f_ok_reg <= e_ok_reg;
        f_r_reg  <= e_r_reg;
        f_u4_reg <= u2u2[32:16];

        g_w_reg  <= f_w_reg;
        g_k_reg  <= f_ok_reg ? kp[32:16] : '0;

        h_tx_reg <= $signed(g_w_reg[95:64]) * $signed({1'b0, g_k_reg});
        h_ty_reg <= $signed(g_w_reg[63:32]) * $signed({1'b0, g_k_reg});
        h_tz_reg <= $signed(g_w_reg[31:0])  * $signed({1'b0, g_k_reg});
    end

    // digit-by-digit square root, two radicand bits per stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_v_reg[0] <= 1'b0;
        end
        else
        begin
            sq_v_reg[0] <= c_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_rem_reg[0]  <= '0;
        sq_root_reg[0] <= '0;
        sq_val_reg[0]  <= c_d2_reg;
        sq_w_reg[0]    <= c_w_reg;
        sq_ok_reg[0]   <= c_ok_reg;
    end

    for (genvar i = 0; i < SQ_STEPS; i++)
    begin : g_sq
        logic [22:0] cur, trial;
        assign cur   = {sq_rem_reg[i][20:0], sq_val_reg[i][39:38]};
        assign trial = {1'b0, sq_root_reg[i], 2'b01};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v_reg[i+1] <= 1'b0;
            end
            else
            begin
                sq_v_reg[i+1] <= sq_v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            sq_val_reg[i+1] <= {sq_val_reg[i][37:0], 2'b00};
            sq_w_reg[i+1]   <= sq_w_reg[i];
            sq_ok_reg[i+1]  <= sq_ok_reg[i];
            if (cur >= trial)
            begin
                sq_rem_reg[i+1]  <= cur - trial;
                sq_root_reg[i+1] <= {sq_root_reg[i][18:0], 1'b1};
            end
            else
            begin
                sq_rem_reg[i+1]  <= cur;
                sq_root_reg[i+1] <= {sq_root_reg[i][18:0], 1'b0};
            end
        end
    end

    for (genvar j = 0; j <= SQ_STEPS; j++)
    begin : g_sqv
        assign sq_v_vec[j] = sq_v_reg[j];
    end

    assign kout.valid = h_v_reg;
    assign kout.tx    = h_tx_reg;
    assign kout.ty    = h_ty_reg;
    assign kout.tz    = h_tz_reg;
    assign busy = a_v_reg | b_v_reg | c_v_reg | (|sq_v_vec) | d_v_reg | e_v_reg
                | f_v_reg | g_v_reg | h_v_reg;
endmodule
